// ===== sv/wckm_pkg.sv =====
package wckm_pkg;

  localparam int CHANNEL_BITS_DEF = 8;
  localparam int PIX_W = 24;
  localparam int STAGES = 6;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_MODE          = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_COLOR     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REPLACE_COLOR = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_RED    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_GREEN  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_BLUE   = 3'd6;

  localparam logic [1:0] MODE_REPLACE = 2'd0;
  localparam logic [1:0] MODE_EXTRACT = 2'd1;
  localparam logic [1:0] MODE_COMPARE = 2'd2;

  localparam logic [7:0] WEIGHT_RED_RST   = 8'd76;
  localparam logic [7:0] WEIGHT_GREEN_RST = 8'd150;
  localparam logic [7:0] WEIGHT_BLUE_RST  = 8'd29;

  // Square of the 0..255 threshold scale.
  localparam logic [15:0] THR_SCALE_SQ = 16'd65025;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_in;
    logic [PIX_W-1:0] other_pixel;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic             within_res;
  } out_item_t;

  typedef struct packed {
    logic [1:0]       mode;
    logic [PIX_W-1:0] key_color;
    logic [PIX_W-1:0] replace_color;
    logic [7:0]       threshold;
    logic [7:0]       weight_red;
    logic [7:0]       weight_green;
    logic [7:0]       weight_blue;
  } cfg_t;

endpackage

// ===== sv/wckm_diff.sv =====
module wckm_diff #(
  parameter int CHANNEL_BITS = wckm_pkg::CHANNEL_BITS_DEF
) (
  input  logic                                clk,
  input  logic [1:0]                          en,
  input  wckm_pkg::in_item_t                  in_item,
  input  wckm_pkg::cfg_t                      cfg,
  output logic [2:0][2*CHANNEL_BITS-1:0]      sq,
  output logic [15:0]                         t2,
  output logic [9:0]                          wsum,
  output logic [wckm_pkg::PIX_W-1:0]          px,
  output logic                                eq
);
  import wckm_pkg::*;

  localparam int CB = CHANNEL_BITS;
  localparam int SQW = 2 * CB;
  localparam int EXT_W = (3 * CB > PIX_W) ? 3 * CB : PIX_W;

  logic [PIX_W-1:0]       b_sel;
  logic [EXT_W-1:0]       a_ext;
  logic [EXT_W-1:0]       b_ext;
  logic [2:0][CB-1:0]     ca;
  logic [2:0][CB-1:0]     cb;
  logic [2:0][CB-1:0]     d_nxt;
  logic [2:0][CB-1:0]     d_r;
  logic [PIX_W-1:0]       px0_r;
  logic                   eq0_r;
  logic [2:0][SQW-1:0]    sq_nxt;
  logic [2:0][SQW-1:0]    sq_r;
  logic [15:0]            t2_r;
  logic [9:0]             wsum_r;
  logic [PIX_W-1:0]       px1_r;
  logic                   eq1_r;

  always_comb begin
    b_sel = (cfg.mode == MODE_COMPARE) ? in_item.other_pixel : cfg.key_color;
    a_ext = EXT_W'(in_item.pixel_in);
    b_ext = EXT_W'(b_sel);
    for (int i = 0; i < 3; i++) begin
      ca[i] = a_ext[i*CB +: CB];
      cb[i] = b_ext[i*CB +: CB];
      d_nxt[i] = (ca[i] > cb[i]) ? ca[i] - cb[i] : cb[i] - ca[i];
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq_nxt[i] = SQW'(d_r[i]) * SQW'(d_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      d_r   <= d_nxt;
      px0_r <= in_item.pixel_in;
      eq0_r <= (in_item.pixel_in == b_sel);
    end
    if (en[1]) begin
      sq_r   <= sq_nxt;
      t2_r   <= 16'(cfg.threshold) * 16'(cfg.threshold);
      wsum_r <= 10'(cfg.weight_red) + 10'(cfg.weight_green) + 10'(cfg.weight_blue);
      px1_r  <= px0_r;
      eq1_r  <= eq0_r;
    end
  end

  assign sq   = sq_r;
  assign t2   = t2_r;
  assign wsum = wsum_r;
  assign px   = px1_r;
  assign eq   = eq1_r;

endmodule

// ===== sv/wckm_dist.sv =====
module wckm_dist #(
  parameter int CHANNEL_BITS = wckm_pkg::CHANNEL_BITS_DEF
) (
  input  logic                              clk,
  input  logic [2:0]                        en,
  input  wckm_pkg::cfg_t                    cfg,
  input  logic [2:0][2*CHANNEL_BITS-1:0]    sq,
  input  logic [15:0]                       t2,
  input  logic [9:0]                        wsum,
  input  logic [wckm_pkg::PIX_W-1:0]        px_in,
  input  logic                              eq_in,
  output logic [2*CHANNEL_BITS+25:0]        lhs,
  output logic [2*CHANNEL_BITS+25:0]        rhs,
  output logic [wckm_pkg::PIX_W-1:0]        px_out,
  output logic                              eq_out
);
  import wckm_pkg::*;

  localparam int CB = CHANNEL_BITS;
  localparam int SQW = 2 * CB;
  localparam int WPW = SQW + 8;
  localparam int SUMW = WPW + 2;
  localparam int CMPW = SUMW + 16;
  localparam int TSW = 26;
  localparam logic [SQW-1:0] MAX_SQ = SQW'(((1 << CB) - 1) * ((1 << CB) - 1));

  logic [2:0][7:0]      wt;
  logic [2:0][WPW-1:0]  wp_r;
  logic [TSW-1:0]       ts_r;
  logic [PIX_W-1:0]     px2_r;
  logic                 eq2_r;
  logic [SUMW-1:0]      sum_r;
  logic [CMPW-1:0]      rhs3_r;
  logic [PIX_W-1:0]     px3_r;
  logic                 eq3_r;
  logic [CMPW-1:0]      lhs4_r;
  logic [CMPW-1:0]      rhs4_r;
  logic [PIX_W-1:0]     px4_r;
  logic                 eq4_r;

  assign wt[2] = cfg.weight_red;
  assign wt[1] = cfg.weight_green;
  assign wt[0] = cfg.weight_blue;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int i = 0; i < 3; i++) begin
        wp_r[i] <= WPW'(wt[i]) * WPW'(sq[i]);
      end
      ts_r  <= TSW'(t2) * TSW'(wsum);
      px2_r <= px_in;
      eq2_r <= eq_in;
    end
    if (en[1]) begin
      sum_r  <= SUMW'(wp_r[0]) + SUMW'(wp_r[1]) + SUMW'(wp_r[2]);
      rhs3_r <= CMPW'(ts_r) * CMPW'(MAX_SQ);
      px3_r  <= px2_r;
      eq3_r  <= eq2_r;
    end
    if (en[2]) begin
      lhs4_r <= CMPW'(sum_r) * CMPW'(THR_SCALE_SQ);
      rhs4_r <= rhs3_r;
      px4_r  <= px3_r;
      eq4_r  <= eq3_r;
    end
  end

  assign lhs    = lhs4_r;
  assign rhs    = rhs4_r;
  assign px_out = px4_r;
  assign eq_out = eq4_r;

endmodule

// ===== sv/wckm_out.sv =====
module wckm_out #(
  parameter int CHANNEL_BITS = wckm_pkg::CHANNEL_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          en,
  input  wckm_pkg::cfg_t                cfg,
  input  logic [2*CHANNEL_BITS+25:0]    lhs,
  input  logic [2*CHANNEL_BITS+25:0]    rhs,
  input  logic [wckm_pkg::PIX_W-1:0]    px,
  input  logic                          eq,
  output wckm_pkg::out_item_t           out_item
);
  import wckm_pkg::*;

  localparam int WB = (3 * CHANNEL_BITS < PIX_W) ? 3 * CHANNEL_BITS : PIX_W;
  localparam logic [PIX_W-1:0] WHITE = {PIX_W{1'b1}} >> (PIX_W - WB);

  logic      hit;
  out_item_t res_nxt;
  out_item_t res_r;

  always_comb begin
    hit = (cfg.threshold == 8'd0) ? eq : (lhs <= rhs);
    res_nxt.within_res = hit;
    case (cfg.mode)
      MODE_REPLACE: res_nxt.pixel_out = hit ? cfg.replace_color : px;
      MODE_EXTRACT: res_nxt.pixel_out = hit ? WHITE : '0;
      MODE_COMPARE: res_nxt.pixel_out = hit ? '0 : WHITE;
      default:      res_nxt.pixel_out = px;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

  assign out_item = res_r;

endmodule

// ===== sv/weighted_color_key_mask.sv =====
// Weighted color key and mask unit.
// Input channel: in_valid/in_ready carry one pixel and a second pixel that
// only compare mode uses. Output channel: out_valid/out_ready carry the
// resulting pixel and the match flag, one result for every input transfer.
// The configuration port writes one register per cycle with cfg_we high;
// the user must change registers only while no pixel is in flight; the block
// itself does not enforce this. The datapath is six register stages:
// absolute differences, squares, weighted products, sum and threshold
// scaling, distance scaling, and the final compare and select. One pixel is
// taken every cycle while the output is not stalled.
// Each stage carries its own valid bit and loads whenever it is empty or its
// successor moves, so bubbles close up while the receiver stalls and no data
// is lost or repeated. in_ready drops only when all six stages are full.
// Reset empties the pipeline and loads the register defaults: replace mode,
// black key and replacement colors, threshold zero and weights 76, 150, 29.
module weighted_color_key_mask #(
  parameter int CHANNEL_BITS = wckm_pkg::CHANNEL_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  wckm_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output wckm_pkg::out_item_t                 out_data,
  input  logic                                cfg_we,
  input  logic [wckm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [wckm_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import wckm_pkg::*;

  localparam int CB = CHANNEL_BITS;

  cfg_t                   cfg_r;
  cfg_t                   cfg_nxt;
  logic [STAGES-1:0]      v_r;
  logic [STAGES-1:0]      v_nxt;
  logic [STAGES-1:0]      stage_en;

  logic [2:0][2*CB-1:0]   sq;
  logic [15:0]            t2;
  logic [9:0]             wsum;
  logic [PIX_W-1:0]       px_a;
  logic                   eq_a;
  logic [2*CB+25:0]       lhs;
  logic [2*CB+25:0]       rhs;
  logic [PIX_W-1:0]       px_b;
  logic                   eq_b;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_MODE:          cfg_nxt.mode = cfg_data[1:0];
        REG_KEY_COLOR:     cfg_nxt.key_color = cfg_data[PIX_W-1:0];
        REG_REPLACE_COLOR: cfg_nxt.replace_color = cfg_data[PIX_W-1:0];
        REG_THRESHOLD:     cfg_nxt.threshold = cfg_data[7:0];
        REG_WEIGHT_RED:    cfg_nxt.weight_red = cfg_data[7:0];
        REG_WEIGHT_GREEN:  cfg_nxt.weight_green = cfg_data[7:0];
        REG_WEIGHT_BLUE:   cfg_nxt.weight_blue = cfg_data[7:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    stage_en[STAGES-1] = !v_r[STAGES-1] || out_ready;
    for (int k = STAGES - 2; k >= 0; k--) begin
      stage_en[k] = !v_r[k] || stage_en[k+1];
    end
    v_nxt[0] = stage_en[0] ? in_valid : v_r[0];
    for (int k = 1; k < STAGES; k++) begin
      v_nxt[k] = stage_en[k] ? v_r[k-1] : v_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r                 <= '0;
      cfg_r.mode          <= MODE_REPLACE;
      cfg_r.key_color     <= '0;
      cfg_r.replace_color <= '0;
      cfg_r.threshold     <= '0;
      cfg_r.weight_red    <= WEIGHT_RED_RST;
      cfg_r.weight_green  <= WEIGHT_GREEN_RST;
      cfg_r.weight_blue   <= WEIGHT_BLUE_RST;
    end else begin
      v_r   <= v_nxt;
      cfg_r <= cfg_nxt;
    end
  end

  wckm_diff #(.CHANNEL_BITS(CHANNEL_BITS)) u_diff (
    .clk     (clk),
    .en      (stage_en[1:0]),
    .in_item (in_data),
    .cfg     (cfg_r),
    .sq      (sq),
    .t2      (t2),
    .wsum    (wsum),
    .px      (px_a),
    .eq      (eq_a)
  );

  wckm_dist #(.CHANNEL_BITS(CHANNEL_BITS)) u_dist (
    .clk    (clk),
    .en     (stage_en[4:2]),
    .cfg    (cfg_r),
    .sq     (sq),
    .t2     (t2),
    .wsum   (wsum),
    .px_in  (px_a),
    .eq_in  (eq_a),
    .lhs    (lhs),
    .rhs    (rhs),
    .px_out (px_b),
    .eq_out (eq_b)
  );

  wckm_out #(.CHANNEL_BITS(CHANNEL_BITS)) u_out (
    .clk      (clk),
    .en       (stage_en[STAGES-1]),
    .cfg      (cfg_r),
    .lhs      (lhs),
    .rhs      (rhs),
    .px       (px_b),
    .eq       (eq_b),
    .out_item (out_data)
  );

  assign in_ready  = stage_en[0];
  assign out_valid = v_r[STAGES-1];

`ifndef ASSERT_OFF
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (v_r == '1))
    else $error("input stalled while a pipeline stage was empty");

  a_transfer_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> v_r[0])
    else $error("accepted transfer did not reach the first stage");

  a_drain_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready |-> in_ready)
    else $error("output transfer did not free the input");
`endif

endmodule

// ===== test/weighted_color_key_mask_tb.sv =====
module weighted_color_key_mask_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import wckm_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic [PIX_W-1:0] WHITE = {PIX_W{1'b1}};
  localparam logic [PIX_W-1:0] BLACK = '0;
  localparam int RANDOM_ITEMS = 500;

  typedef struct {
    logic [1:0]       mode;
    logic [PIX_W-1:0] key_color;
    logic [PIX_W-1:0] replace_color;
    logic [7:0]       threshold;
    logic [7:0]       weight_red;
    logic [7:0]       weight_green;
    logic [7:0]       weight_blue;
    logic [PIX_W-1:0] pixel_in;
    logic [PIX_W-1:0] other_pixel;
    bit               typed;
    logic [PIX_W-1:0] want_pixel;
    logic             want_within;
  } key_row_t;

  // A row with typed cleared is checked against the predictor instead.
  key_row_t key_plan [22] = '{
    '{MODE_REPLACE, 24'h000000, 24'h000000, 8'd0, 8'd76, 8'd150, 8'd29,
      24'h000000, 24'hFFFFFF, 1, 24'h000000, 1'b1},
    '{MODE_REPLACE, 24'h000000, 24'h000000, 8'd0, 8'd76, 8'd150, 8'd29,
      24'hFFFFFF, 24'h000000, 1, 24'hFFFFFF, 1'b0},
    '{MODE_REPLACE, 24'h000000, 24'h000000, 8'd0, 8'd76, 8'd150, 8'd29,
      24'h000001, 24'hFFFFFF, 1, 24'h000001, 1'b0},
    '{MODE_REPLACE, 24'h123456, 24'hABCDEF, 8'd0, 8'd76, 8'd150, 8'd29,
      24'h123456, 24'h000000, 1, 24'hABCDEF, 1'b1},
    '{MODE_REPLACE, 24'h123456, 24'hABCDEF, 8'd0, 8'd76, 8'd150, 8'd29,
      24'h123457, 24'h123456, 1, 24'h123457, 1'b0},
    '{MODE_EXTRACT, 24'h000000, 24'hABCDEF, 8'd255, 8'd76, 8'd150, 8'd29,
      24'hFFFFFF, 24'h000000, 1, WHITE, 1'b1},
    '{MODE_EXTRACT, 24'h000000, 24'hABCDEF, 8'd255, 8'd76, 8'd150, 8'd29,
      24'h808080, 24'h000000, 1, WHITE, 1'b1},
    '{MODE_EXTRACT, 24'h808080, 24'hABCDEF, 8'd1, 8'd76, 8'd150, 8'd29,
      24'h808080, 24'hFFFFFF, 1, WHITE, 1'b1},
    '{MODE_EXTRACT, 24'h808080, 24'hABCDEF, 8'd1, 8'd76, 8'd150, 8'd29,
      24'h818080, 24'hFFFFFF, 0, BLACK, 1'b0},
    '{MODE_EXTRACT, 24'h808080, 24'hABCDEF, 8'd1, 8'd76, 8'd150, 8'd29,
      24'h000000, 24'hFFFFFF, 0, BLACK, 1'b0},
    '{MODE_COMPARE, 24'h808080, 24'hABCDEF, 8'd0, 8'd76, 8'd150, 8'd29,
      24'hAAAAAA, 24'hAAAAAA, 1, BLACK, 1'b1},
    '{MODE_COMPARE, 24'h808080, 24'hABCDEF, 8'd0, 8'd76, 8'd150, 8'd29,
      24'hAAAAAA, 24'hAAAAAB, 1, WHITE, 1'b0},
    '{MODE_COMPARE, 24'h808080, 24'hABCDEF, 8'd10, 8'd255, 8'd255, 8'd255,
      24'h102030, 24'h102030, 1, BLACK, 1'b1},
    '{MODE_COMPARE, 24'h808080, 24'hABCDEF, 8'd10, 8'd255, 8'd255, 8'd255,
      24'h000000, 24'hFFFFFF, 1, WHITE, 1'b0},
    '{MODE_COMPARE, 24'h808080, 24'hABCDEF, 8'd10, 8'd255, 8'd255, 8'd255,
      24'h0A0000, 24'h000000, 0, BLACK, 1'b0},
    '{MODE_EXTRACT, 24'h000000, 24'hABCDEF, 8'd5, 8'd0, 8'd0, 8'd0,
      24'hFFFFFF, 24'h000000, 1, WHITE, 1'b1},
    '{MODE_UNUSED, 24'h00FF00, 24'hABCDEF, 8'd0, 8'd76, 8'd150, 8'd29,
      24'h00FF00, 24'h000000, 1, 24'h00FF00, 1'b1},
    '{MODE_UNUSED, 24'h00FF00, 24'hABCDEF, 8'd0, 8'd76, 8'd150, 8'd29,
      24'h123456, 24'h00FF00, 1, 24'h123456, 1'b0},
    '{MODE_REPLACE, 24'hFFFFFF, 24'h5A5A5A, 8'd128, 8'd0, 8'd255, 8'd0,
      24'h00FF00, 24'h000000, 1, 24'h5A5A5A, 1'b1},
    '{MODE_REPLACE, 24'hFFFFFF, 24'h5A5A5A, 8'd128, 8'd0, 8'd255, 8'd0,
      24'hFF00FF, 24'h000000, 1, 24'hFF00FF, 1'b0},
    '{MODE_REPLACE, 24'hFFFFFF, 24'h5A5A5A, 8'd128, 8'd0, 8'd255, 8'd0,
      24'hFF80FF, 24'h000000, 0, BLACK, 1'b0},
    '{MODE_REPLACE, 24'h000000, 24'hFFFFFF, 8'd255, 8'd255, 8'd255, 8'd255,
      24'hFFFFFF, 24'h000000, 1, 24'hFFFFFF, 1'b1}
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  cfg_t active_regs;
  out_item_t results_due[$];
  int err_count = 0;
  int burst_left = 0;
  int stall_style = 0;
  int stall_span = 0;

  weighted_color_key_mask uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  function automatic logic colors_within(cfg_t c, logic [PIX_W-1:0] a, logic [PIX_W-1:0] b);
    logic [63:0] lhs;
    logic [63:0] rhs;
    logic [63:0] wsum;
    logic [63:0] ca;
    logic [63:0] cb;
    logic [63:0] d;
    logic [63:0] w;
    if (c.threshold == 8'd0) begin
      return a == b;
    end
    lhs = '0;
    for (int ch = 0; ch < 3; ch++) begin
      ca = 64'(a[ch*8 +: 8]);
      cb = 64'(b[ch*8 +: 8]);
      d = (ca > cb) ? ca - cb : cb - ca;
      w = (ch == 2) ? 64'(c.weight_red) : (ch == 1) ? 64'(c.weight_green) :
          64'(c.weight_blue);
      lhs += w * d * d;
    end
    lhs = lhs * 64'(THR_SCALE_SQ);
    wsum = 64'(c.weight_red) + 64'(c.weight_green) + 64'(c.weight_blue);
    rhs = 64'(c.threshold) * 64'(c.threshold) * 64'(THR_SCALE_SQ) * wsum;
    return lhs <= rhs;
  endfunction

  function automatic out_item_t predict_key(cfg_t c, in_item_t x);
    out_item_t r;
    if (c.mode == MODE_COMPARE) begin
      r.within_res = colors_within(c, x.pixel_in, x.other_pixel);
      r.pixel_out = r.within_res ? BLACK : WHITE;
    end else begin
      r.within_res = colors_within(c, x.pixel_in, c.key_color);
      case (c.mode)
        MODE_REPLACE: r.pixel_out = r.within_res ? c.replace_color : x.pixel_in;
        MODE_EXTRACT: r.pixel_out = r.within_res ? WHITE : BLACK;
        default:      r.pixel_out = x.pixel_in;
      endcase
    end
    return r;
  endfunction

  function automatic logic [7:0] pick_weight();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return 8'd0;
    if (sel == 1) return 8'd255;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic cfg_t pick_regs();
    cfg_t c;
    int sel;
    sel = $urandom_range(0, 12);
    c.mode = (sel == 12) ? MODE_UNUSED : 2'(sel % 3);
    c.key_color = PIX_W'($urandom());
    c.replace_color = PIX_W'($urandom());
    sel = $urandom_range(0, 19);
    if (sel < 3) c.threshold = 8'd0;
    else if (sel < 5) c.threshold = 8'd255;
    else if (sel < 13) c.threshold = 8'($urandom_range(1, 20));
    else c.threshold = 8'($urandom_range(1, 255));
    c.weight_red = pick_weight();
    c.weight_green = pick_weight();
    c.weight_blue = pick_weight();
    if ($urandom_range(0, 19) == 0) begin
      c.weight_red = 8'd0;
      c.weight_green = 8'd0;
      c.weight_blue = 8'd0;
    end
    return c;
  endfunction

  function automatic logic [PIX_W-1:0] nudge_color(logic [PIX_W-1:0] base, int spread);
    logic [PIX_W-1:0] r;
    int v;
    for (int ch = 0; ch < 3; ch++) begin
      v = int'(base[ch*8 +: 8]) + int'($urandom_range(0, 2 * spread)) - spread;
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      r[ch*8 +: 8] = 8'(v);
    end
    return r;
  endfunction

  function automatic in_item_t pick_pixels(cfg_t c);
    in_item_t x;
    int sel;
    int spread;
    sel = $urandom_range(0, 9);
    spread = (c.threshold == 8'd0) ? int'($urandom_range(0, 1)) :
             int'(c.threshold) + int'($urandom_range(0, 8));
    if (spread > 255) spread = 255;
    x.pixel_in = PIX_W'($urandom());
    x.other_pixel = PIX_W'($urandom());
    if (sel >= 2) begin
      if (c.mode == MODE_COMPARE) begin
        x.other_pixel = (sel == 2) ? x.pixel_in : nudge_color(x.pixel_in, spread);
      end else begin
        x.pixel_in = (sel == 2) ? c.key_color : nudge_color(c.key_color, spread);
      end
    end
    return x;
  endfunction

  task automatic poke_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
  endtask

  task automatic load_regs(input cfg_t c);
    poke_reg(REG_MODE, CFG_DATA_W'(c.mode));
    poke_reg(REG_KEY_COLOR, CFG_DATA_W'(c.key_color));
    poke_reg(REG_REPLACE_COLOR, CFG_DATA_W'(c.replace_color));
    poke_reg(REG_THRESHOLD, CFG_DATA_W'(c.threshold));
    poke_reg(REG_WEIGHT_RED, CFG_DATA_W'(c.weight_red));
    poke_reg(REG_WEIGHT_GREEN, CFG_DATA_W'(c.weight_green));
    poke_reg(REG_WEIGHT_BLUE, CFG_DATA_W'(c.weight_blue));
    @(negedge clk);
    cfg_we = 1'b0;
    active_regs = c;
  endtask

  task automatic drain_pipe();
    @(negedge clk);
    in_valid = 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic send_pixels(input in_item_t x, input bit typed, input out_item_t want);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 8));
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        @(negedge clk);
        in_valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid = 1'b1;
    in_data = x;
    do @(posedge clk); while (!in_ready);
    results_due.push_back(typed ? want : predict_key(active_regs, x));
  endtask

  always @(negedge clk) begin
    if (stall_span == 0) begin
      stall_style = $urandom_range(0, 2);
      stall_span = $urandom_range(16, 96);
    end
    stall_span--;
    case (stall_style)
      0: out_ready = 1'b1;
      1: out_ready = 1'($urandom_range(0, 1));
      default: out_ready = ($urandom_range(0, 3) == 0);
    endcase
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (results_due.size() == 0) begin
        $display("%0t: unexpected transfer, expected none, actual %06h/%0b",
                 $time, out_data.pixel_out, out_data.within_res);
        err_count++;
      end else begin
        want = results_due.pop_front();
        if (out_data.pixel_out !== want.pixel_out) begin
          $display("%0t: pixel_out expected %06h actual %06h",
                   $time, want.pixel_out, out_data.pixel_out);
          err_count++;
        end
        if (out_data.within_res !== want.within_res) begin
          $display("%0t: within_res expected %0b actual %0b",
                   $time, want.within_res, out_data.within_res);
          err_count++;
        end
      end
    end
  end

  initial begin
    #3000000;
    $display("weighted_color_key_mask_tb: errors");
    $finish;
  end

  initial begin
    cfg_t row_regs;
    in_item_t x;
    out_item_t want;
    int sent;
    int phase_len;
    bit first;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    first = 1'b1;
    foreach (key_plan[i]) begin
      row_regs.mode = key_plan[i].mode;
      row_regs.key_color = key_plan[i].key_color;
      row_regs.replace_color = key_plan[i].replace_color;
      row_regs.threshold = key_plan[i].threshold;
      row_regs.weight_red = key_plan[i].weight_red;
      row_regs.weight_green = key_plan[i].weight_green;
      row_regs.weight_blue = key_plan[i].weight_blue;
      if (first || row_regs != active_regs) begin
        drain_pipe();
        load_regs(row_regs);
        first = 1'b0;
      end
      x.pixel_in = key_plan[i].pixel_in;
      x.other_pixel = key_plan[i].other_pixel;
      want.pixel_out = key_plan[i].want_pixel;
      want.within_res = key_plan[i].want_within;
      send_pixels(x, key_plan[i].typed, want);
    end
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      drain_pipe();
      load_regs(pick_regs());
      phase_len = $urandom_range(10, 50);
      repeat (phase_len) begin
        send_pixels(pick_pixels(active_regs), 1'b0, '0);
        sent++;
      end
    end
    drain_pipe();
    if (err_count == 0) begin
      $display("weighted_color_key_mask_tb: clean");
    end else begin
      $display("weighted_color_key_mask_tb: errors");
    end
    $finish;
  end

endmodule
